// ===== hdl/assert_macros.svh =====
// assertion helpers used by gbs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/gbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

    // configuration register indexes
    localparam logic CFG_IOU_THRESHOLD  = 1'b0;
    localparam logic CFG_CLASS_AGNOSTIC = 1'b1;

    // reset values of the configuration registers
    localparam logic [8:0] IOU_THRESHOLD_RESET = 9'd115;

    // box as classified by the front end, corners precomputed
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [17:0] right;
        logic [17:0] bottom;
        logic [31:0] area;
        logic [7:0]  label;
        logic        first;
    } t_box;

    // one entry of the kept list
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [17:0] right;
        logic [17:0] bottom;
        logic [31:0] area;
        logic [7:0]  label;
    } t_kept;

    // one result word
    typedef struct packed {
        logic       keep;
        logic [5:0] slot;
        logic       full;
    } t_res;

    // configuration seen by the suppression engine
    typedef struct packed {
        logic [8:0] iou_threshold;
        logic       class_agnostic;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/greedy_box_suppression.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Greedy non-maximum suppression over boxes that arrive sorted by falling score.
// Each box is checked against every kept box of its class (all classes when
// class_agnostic is set) and is kept unless intersection*256 > threshold*union
// or the kept list is already full. The engine scans the kept list, reading one
// kept entry per cycle from the single read port of the kept-list RAM, followed
// by a five-stage compare pipeline that must drain before the verdict.
// Two-word queues sit between the front and the scan engine and on the result
// side. The kept list needs no clearing after reset.

module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [15:0] i_box_left,
    input  wire  [15:0] i_box_top,
    input  wire  [15:0] i_box_width,
    input  wire  [15:0] i_box_height,
    input  wire  [7:0]  i_class_label,
    input  wire         i_first_box,
    output logic        empty,
    input  wire         pop,
    output logic        o_keep,
    output logic [5:0]  o_kept_slot,
    output logic        o_list_full,
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_idx,
    input  wire  [8:0]  i_cfg_wdata
);

    t_cfg r_cfg;
    t_box mid_box;
    logic mid_empty;
    logic mid_pop;
    logic res_full;
    logic res_push;
    t_res res_in;
    logic [$bits(t_res)-1:0] res_rdata;
    t_res res_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iou_threshold  <= IOU_THRESHOLD_RESET;
            r_cfg.class_agnostic <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_IOU_THRESHOLD:  r_cfg.iou_threshold  <= i_cfg_wdata;
                CFG_CLASS_AGNOSTIC: r_cfg.class_agnostic <= i_cfg_wdata[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // input side
    gbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_class_label (i_class_label),
        .i_first_box   (i_first_box),
        .i_pop         (mid_pop),
        .o_empty       (mid_empty),
        .o_box         (mid_box)
    );

    // suppression engine
    gbs_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_empty (mid_empty),
        .i_box      (mid_box),
        .o_in_pop   (mid_pop),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_res      (res_in)
    );

    // result queue
    gbs_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign res_out     = t_res'(res_rdata);
    assign o_keep      = res_out.keep;
    assign o_kept_slot = res_out.slot;
    assign o_list_full = res_out.full;

endmodule

`default_nettype wire

// ===== hdl/gbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  wire                                     i_clk,
    input  wire                                     i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [W-1:0]                            i_wdata,
    input  wire                                     i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                            o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gbs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire  [W-1:0] i_wdata,
    output logic         o_full,
    input  wire          i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr;
    logic          rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbs_front
    import gbs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire  [15:0] i_box_left,
    input  wire  [15:0] i_box_top,
    input  wire  [15:0] i_box_width,
    input  wire  [15:0] i_box_height,
    input  wire  [7:0]  i_class_label,
    input  wire         i_first_box,
    input  wire         i_pop,
    output logic        o_empty,
    output t_box        o_box
);

    t_box box_in;
    logic [(2 * $bits(t_box))/2-1:0] q_rdata;

    // far corners and area of the incoming word
    always_comb begin
        box_in.left   = i_box_left;
        box_in.top    = i_box_top;
        box_in.right  = 18'($signed({{2{i_box_left[15]}}, i_box_left}) +
                            $signed({2'b00, i_box_width}));
        box_in.bottom = 18'($signed({{2{i_box_top[15]}}, i_box_top}) +
                            $signed({2'b00, i_box_height}));
        box_in.area   = i_box_width * i_box_height;
        box_in.label  = i_class_label;
        box_in.first  = i_first_box;
    end

    // queue towards the suppression engine
    gbs_fifo #(
        .W     ($bits(t_box)),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (box_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_rdata (q_rdata),
        .o_empty (o_empty)
    );

    assign o_box = t_box'(q_rdata);

endmodule

`default_nettype wire

// ===== hdl/gbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gbs_back
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = 64
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire   i_in_empty,
    input  wire t_box i_box,
    output logic  o_in_pop,
    input  wire   i_out_full,
    output logic  o_out_push,
    output t_res  o_res
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    t_box          r_cur;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic          r_hit;

    // compare pipeline
    logic          r_v_rd, r_v1, r_v2, r_v3, r_v4;
    logic [16:0]   r_ow, r_oh;
    logic [31:0]   r_karea;
    logic [33:0]   r_inter2, r_inter3;
    logic [32:0]   r_sum;
    logic [32:0]   r_uni;
    logic [41:0]   r_prod, r_i256;

    t_kept         rd_kept;
    logic [$bits(t_kept)-1:0] ram_rdata;
    t_kept         wr_kept;
    logic          rd_en;
    logic          wr_en;
    logic          busy_pipe;
    logic          keep_now;
    logic          full_now;
    logic          match;
    logic signed [17:0] cur_l, cur_r, cur_t, cur_b;
    logic signed [17:0] k_l, k_r, k_t, k_b;
    logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [18:0] dx, dy;

    assign rd_kept   = t_kept'(ram_rdata);
    assign rd_en     = (r_state == S_SCAN) && (r_idx != r_cnt);
    assign busy_pipe = r_v_rd || r_v1 || r_v2 || r_v3 || r_v4;
    assign keep_now  = !r_hit && (r_cnt < CW'(MAX_KEPT));
    assign full_now  = !r_hit && (r_cnt == CW'(MAX_KEPT));
    assign wr_en     = (r_state == S_DONE) && keep_now;
    assign o_in_pop  = (r_state == S_IDLE) && !i_in_empty && !i_out_full;
    assign o_out_push = (r_state == S_DONE);

    // result word
    always_comb begin
        o_res.keep = keep_now;
        o_res.slot = keep_now ? 6'(r_cnt) : 6'd0;
        o_res.full = full_now;
    end

    // entry to append
    always_comb begin
        wr_kept.left   = r_cur.left;
        wr_kept.top    = r_cur.top;
        wr_kept.right  = r_cur.right;
        wr_kept.bottom = r_cur.bottom;
        wr_kept.area   = r_cur.area;
        wr_kept.label  = r_cur.label;
    end

    // kept list storage
    gbs_ram #(
        .W     ($bits(t_kept)),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (wr_kept),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // overlap in each axis against the entry just read
    always_comb begin
        cur_l = $signed({{2{r_cur.left[15]}}, r_cur.left});
        cur_t = $signed({{2{r_cur.top[15]}}, r_cur.top});
        cur_r = $signed(r_cur.right);
        cur_b = $signed(r_cur.bottom);
        k_l   = $signed({{2{rd_kept.left[15]}}, rd_kept.left});
        k_t   = $signed({{2{rd_kept.top[15]}}, rd_kept.top});
        k_r   = $signed(rd_kept.right);
        k_b   = $signed(rd_kept.bottom);
        lo_x  = (cur_l > k_l) ? cur_l : k_l;
        hi_x  = (cur_r < k_r) ? cur_r : k_r;
        lo_y  = (cur_t > k_t) ? cur_t : k_t;
        hi_y  = (cur_b < k_b) ? cur_b : k_b;
        dx    = $signed({hi_x[17], hi_x}) - $signed({lo_x[17], lo_x});
        dy    = $signed({hi_y[17], hi_y}) - $signed({lo_y[17], lo_y});
        match = i_cfg.class_agnostic || (rd_kept.label == r_cur.label);
    end

    // compare pipeline datapath
    always_ff @(posedge i_clk) begin
        r_ow     <= (dx > 19'sd0) ? dx[16:0] : 17'd0;
        r_oh     <= (dy > 19'sd0) ? dy[16:0] : 17'd0;
        r_karea  <= rd_kept.area;
        r_inter2 <= r_ow * r_oh;
        r_sum    <= {1'b0, r_cur.area} + {1'b0, r_karea};
        r_inter3 <= r_inter2;
        r_uni    <= 33'({1'b0, r_sum} - r_inter2);
        r_prod   <= i_cfg.iou_threshold * r_uni;
        r_i256   <= {r_inter3, 8'd0};
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_in_pop) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == r_cnt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!busy_pipe) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer, list count and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_v_rd  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v_rd  <= rd_en;
            r_v1    <= r_v_rd && match;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (o_in_pop) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                if (i_box.first) begin
                    r_cnt <= '0;
                end
            end else begin
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_v4 && (r_i256 > r_prod)) begin
                    r_hit <= 1'b1;
                end
                if (wr_en) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // current box
    always_ff @(posedge i_clk) begin
        if (o_in_pop) begin
            r_cur <= i_box;
        end
    end

    `ASSERT_CLK(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_KEPT), "kept count beyond list size")
    `ASSERT_CLK(a_done_drained, i_clk, i_rst_n, (r_state == S_DONE) |-> !busy_pipe, "verdict taken with compares in flight")
    `ASSERT_NEVER(a_rw_clash, i_clk, i_rst_n, rd_en && wr_en, "kept list read and written together")
    `ASSERT_CLK(a_push_room, i_clk, i_rst_n, o_out_push |-> !i_out_full, "result pushed into a full queue")

endmodule

`default_nettype wire

// ===== test/tb_greedy_box_suppression.sv =====
`timescale 1ns / 1ps

// predicts the keep verdict of each box and checks the result words in order
class suppression_scoreboard #(int DEPTH = 64);
    // kept list as the block should hold it
    logic [15:0]   kept_left[DEPTH];
    logic [15:0]   kept_top[DEPTH];
    logic [15:0]   kept_wid[DEPTH];
    logic [15:0]   kept_hgt[DEPTH];
    logic [7:0]    kept_label[DEPTH];
    longint        kept_area[DEPTH];
    int            kept_total;
    logic [8:0]    iou_limit;
    logic          any_class;
    gbs_pkg::t_res verdicts[$];
    int            errors;

    function new();
        kept_total = 0;
        iou_limit  = gbs_pkg::IOU_THRESHOLD_RESET;
        any_class  = 1'b0;
        errors     = 0;
    endfunction

    function void configure(logic idx, logic [8:0] data);
        case (idx)
            gbs_pkg::CFG_IOU_THRESHOLD:  iou_limit = data;
            gbs_pkg::CFG_CLASS_AGNOSTIC: any_class = data[0];
            default: ;
        endcase
    endfunction

    // length of the overlap of two spans, zero when they are apart
    function longint span(longint a0, longint a1, longint b0, longint b1);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function void note_box(logic [15:0] left, logic [15:0] top, logic [15:0] wid,
                           logic [15:0] hgt, logic [7:0] label, logic first);
        longint        l0, t0, w, h, area, k0, q0, inter, joint;
        logic          survives;
        gbs_pkg::t_res v;
        l0 = longint'($signed(left));
        t0 = longint'($signed(top));
        w = wid;
        h = hgt;
        area = w * h;
        survives = 1'b1;
        if (first) kept_total = 0;
        // greedy scan over the kept list
        for (int j = 0; j < kept_total; j++) begin
            if (!any_class && kept_label[j] != label) continue;
            k0 = longint'($signed(kept_left[j]));
            q0 = longint'($signed(kept_top[j]));
            inter = span(l0, l0 + w, k0, k0 + longint'(kept_wid[j])) *
                    span(t0, t0 + h, q0, q0 + longint'(kept_hgt[j]));
            joint = area + kept_area[j] - inter;
            if (inter * 256 > longint'(iou_limit) * joint) begin
                survives = 1'b0;
                break;
            end
        end
        v = '0;
        if (survives && kept_total >= DEPTH) begin
            v.full = 1'b1;
        end else if (survives) begin
            kept_left[kept_total]  = left;
            kept_top[kept_total]   = top;
            kept_wid[kept_total]   = wid;
            kept_hgt[kept_total]   = hgt;
            kept_label[kept_total] = label;
            kept_area[kept_total]  = area;
            v.keep = 1'b1;
            v.slot = 6'(kept_total);
            kept_total++;
        end
        verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_verdict(logic keep, logic [5:0] slot, logic full);
        gbs_pkg::t_res want;
        if (verdicts.size() == 0) begin
            $display("%0t: result word with nothing pending: keep=%0b slot=%0d full=%0b",
                     $time, keep, slot, full);
            errors++;
            return;
        end
        want = verdicts.pop_front();
        if (keep !== want.keep) begin
            $display("%0t: keep expected %0b actual %0b", $time, want.keep, keep);
            errors++;
        end
        if (slot !== want.slot) begin
            $display("%0t: kept_slot expected %0d actual %0d", $time, want.slot, slot);
            errors++;
        end
        if (full !== want.full) begin
            $display("%0t: list_full expected %0b actual %0b", $time, want.full, full);
            errors++;
        end
    endfunction

    function int pending();
        return verdicts.size();
    endfunction
endclass

module tb_greedy_box_suppression;
    import gbs_pkg::*;

    localparam int MAX_KEPT     = 64;
    localparam int SETTLE       = MAX_KEPT + 8;
    localparam int LIMIT_CYCLES = 600000;
    localparam int BOX_TARGET   = 1150;
    localparam int PHASES       = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_box_left;
    logic [15:0] i_box_top;
    logic [15:0] i_box_width;
    logic [15:0] i_box_height;
    logic [7:0]  i_class_label;
    logic        i_first_box;
    logic        empty;
    logic        pop;
    logic        o_keep;
    logic [5:0]  o_kept_slot;
    logic        o_list_full;
    logic        i_cfg_wr_en;
    logic        i_cfg_idx;
    logic [8:0]  i_cfg_wdata;

    suppression_scoreboard #(MAX_KEPT) sb;
    int unsigned cycles = 0;
    int          boxes_sent = 0;
    bit          quiet_push = 1'b0;
    bit          quiet_pop = 1'b0;

    greedy_box_suppression #(.MAX_KEPT(MAX_KEPT)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_class_label (i_class_label),
        .i_first_box   (i_first_box),
        .empty         (empty),
        .pop           (pop),
        .o_keep        (o_keep),
        .o_kept_slot   (o_kept_slot),
        .o_list_full   (o_list_full),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_greedy_box_suppression: errors");
            $finish;
        end
    end

    // result side: random pop gaps (none when quiet_pop is set), each word checked when taken
    initial begin : result_side
        int gap;
        pop = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = quiet_pop ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                @(negedge i_clk);
                pop <= 1'b0;
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_verdict(o_keep, o_kept_slot, o_list_full);
        end
    end

    task automatic send_box(logic [15:0] left, logic [15:0] top, logic [15:0] wid,
                            logic [15:0] hgt, logic [7:0] label, logic first);
        int gap;
        gap = quiet_push ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_box_left    <= left;
        i_box_top     <= top;
        i_box_width   <= wid;
        i_box_height  <= hgt;
        i_class_label <= label;
        i_first_box   <= first;
        do @(posedge i_clk); while (full);
        sb.note_box(left, top, wid, hgt, label, first);
        boxes_sent++;
    endtask

    // hold off the sender until every pending word has been taken
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.configure(idx, data);
    endtask

    // one frame of boxes; spread frames are laid out side by side to fill the list
    task automatic run_frame(int len, bit spread);
        int          cx[4], cy[4], cw[4], ch[4];
        int          c, mode;
        logic [15:0] l, t, w, h;
        logic [7:0]  lab;
        logic        fst;
        for (int i = 0; i < 4; i++) begin
            cx[i] = int'($urandom_range(0, 60000)) - 30000;
            cy[i] = int'($urandom_range(0, 60000)) - 30000;
            cw[i] = int'($urandom_range(160, 1600));
            ch[i] = int'($urandom_range(160, 1600));
        end
        for (int k = 0; k < len; k++) begin
            mode = $urandom_range(0, 15);
            c = $urandom_range(0, 3);
            fst = (k == 0) || (!spread && $urandom_range(0, 49) == 0);
            if (mode == 0) begin
                l = 16'($urandom);
                t = 16'($urandom);
                w = 16'($urandom);
                h = 16'($urandom);
                lab = 8'($urandom);
            end else if (spread) begin
                l = 16'(k * 700 - 32768 + int'($urandom_range(0, 15)));
                t = 16'(int'($urandom_range(0, 60000)) - 30000);
                w = 16'($urandom_range(256, 600));
                h = 16'($urandom_range(16, 4000));
                lab = 8'($urandom_range(0, 3));
            end else begin
                l = 16'(cx[c] + int'($urandom_range(0, 96)) - 48);
                t = 16'(cy[c] + int'($urandom_range(0, 96)) - 48);
                w = 16'(cw[c] + int'($urandom_range(0, 64)));
                h = 16'(ch[c] + int'($urandom_range(0, 64)));
                lab = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'(c);
                // degenerate box inside a cluster
                if (mode == 1) begin
                    if ($urandom_range(0, 1) == 1) w = '0;
                    else h = '0;
                end
            end
            send_box(l, t, w, h, lab, fst);
        end
    endtask

    initial begin : stimulus
        logic [8:0] thr;
        int         target;
        int         frame_no;
        sb            = new();
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_box_left    = '0;
        i_box_top     = '0;
        i_box_width   = '0;
        i_box_height  = '0;
        i_class_label = '0;
        i_first_box   = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = CFG_IOU_THRESHOLD;
        i_cfg_wdata   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_IOU_THRESHOLD, IOU_THRESHOLD_RESET);
        write_reg(CFG_CLASS_AGNOSTIC, 9'd0);

        // largest box at the lowest corner, then a duplicate and another class
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 8'd0, 1'b1);
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0);
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 8'd1, 1'b0);
        // highest corner, touching the first box only at its edge
        send_box(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0);
        // zero width and zero height
        send_box(16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 8'd0, 1'b0);
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 8'd0, 1'b0);
        // small boxes: apart, touching, half overlap, heavy overlap
        send_box(16'd0, 16'd0, 16'd16, 16'd16, 8'd2, 1'b0);
        send_box(16'd16, 16'd0, 16'd16, 16'd16, 8'd2, 1'b0);
        send_box(16'd8, 16'd0, 16'd16, 16'd16, 8'd2, 1'b0);
        send_box(16'd2, 16'd0, 16'd16, 16'd16, 8'd2, 1'b0);
        send_box(16'd100, 16'd100, 16'd32, 16'd32, 8'hFF, 1'b0);
        // fresh list
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 8'd0, 1'b1);
        send_box(16'd0, 16'd0, 16'd16, 16'd16, 8'd9, 1'b0);

        // all classes compared
        drain();
        write_reg(CFG_CLASS_AGNOSTIC, 9'd1);
        send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 8'd7, 1'b0);
        send_box(16'd0, 16'd0, 16'd16, 16'd16, 8'd9, 1'b0);

        // zero threshold: any overlap suppresses
        drain();
        write_reg(CFG_IOU_THRESHOLD, 9'd0);
        send_box(16'd10, 16'd10, 16'd16, 16'd16, 8'd3, 1'b0);

        // full-scale and over-range thresholds never suppress
        drain();
        write_reg(CFG_IOU_THRESHOLD, 9'd256);
        send_box(16'd0, 16'd0, 16'd16, 16'd16, 8'd9, 1'b0);
        drain();
        write_reg(CFG_IOU_THRESHOLD, 9'h1FF);
        send_box(16'd0, 16'd0, 16'd16, 16'd16, 8'd9, 1'b0);

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: thr = 9'd0;
                1: thr = 9'd256;
                2: thr = IOU_THRESHOLD_RESET;
                3: thr = 9'h1FF;
                4: thr = 9'd1;
                default: thr = 9'($urandom_range(1, 255));
            endcase
            write_reg(CFG_IOU_THRESHOLD, thr);
            write_reg(CFG_CLASS_AGNOSTIC, 9'(p % 2));
            quiet_push = ($urandom_range(0, 3) == 0);
            quiet_pop = ($urandom_range(0, 3) == 0);
            target = BOX_TARGET * (p + 1) / PHASES;
            frame_no = 0;
            while (boxes_sent < target) begin
                if (frame_no % 5 == 4) run_frame($urandom_range(66, 80), 1'b1);
                else run_frame($urandom_range(1, 24), 1'b0);
                frame_no++;
                if ($urandom_range(0, 7) == 0) drain();
            end
        end

        // wind down
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d result words never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_greedy_box_suppression: clean");
        end else begin
            $display("tb_greedy_box_suppression: errors");
        end
        $finish;
    end

endmodule
